FILE: hdl/capt_pkg.sv
`default_nettype none

package capt_pkg;

   localparam int INDEX_WIDTH       = 6;
   localparam int DIST_WIDTH        = 32;
   localparam int COUNT_WIDTH       = 7;
   localparam int DEFAULT_MAX_ITEMS = 64;

   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_RETIRE     = 2'd1;
   localparam logic [1:0] OP_FIND       = 2'd2;
   localparam logic [1:0] OP_REACTIVATE = 2'd3;

   typedef struct packed {
      logic [1:0]             operation;
      logic [INDEX_WIDTH-1:0] first_index;
      logic [INDEX_WIDTH-1:0] second_index;
      logic [DIST_WIDTH-1:0]  distance;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] closest_first;
      logic [INDEX_WIDTH-1:0] closest_second;
      logic [DIST_WIDTH-1:0]  closest_distance;
      logic                   pair_found;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/closest_active_pair_table.sv
// Write, retire and reactivate complete in the cycle of their transfer; busy stays low.
// A find scans all n*(n-1)/2 pairs of the n items in use, one table read per cycle through
// the single read port, then a drain state, then the result strobe (which comes in the cycle
// after the transfer when fewer than two items are in use). The next item is taken the cycle
// after the strobe. The receiver cannot stall. Reset sets every item active and the item
// count to zero; table contents are undefined until written.
`default_nettype none

module closest_active_pair_table
   import capt_pkg::*;
#(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [COUNT_WIDTH-1:0] csr_data
);

   localparam int SPAN      = 2 ** INDEX_WIDTH;
   localparam int TABLE_DIM = (MAX_ITEMS < SPAN) ? MAX_ITEMS : SPAN;
   localparam int IW        = $clog2(TABLE_DIM);
   localparam int ADDR_W    = 2 * IW;
   localparam int DEPTH     = 2 ** ADDR_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_REPLY = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] item_count_ff, item_count_in;
   logic [TABLE_DIM-1:0]   active_ff, active_in;
   logic [IW-1:0]          i_ff, i_in, j_ff, j_in;
   logic                   p_valid_ff, p_valid_in;
   logic [IW-1:0]          p_i_ff, p_i_in, p_j_ff, p_j_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          best_i_ff, best_i_in, best_j_ff, best_j_in;
   logic [DIST_WIDTH-1:0]  best_d_ff, best_d_in;

   logic [COUNT_WIDTH-1:0] n_use;
   logic                   accept, take, last_col, last_row;
   logic                   wr_en;
   logic [IW-1:0]          a_idx, b_idx, lo_idx, hi_idx;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic [DIST_WIDTH-1:0]  rd_data;

   capt_ram #(
      .WIDTH(DIST_WIDTH),
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_data.distance),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   // A register write waits while an item is offered, so the two never share an edge.
   assign csr_ready = !busy && !start;
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_REPLY);

   assign rsp_data.closest_first    = INDEX_WIDTH'(best_i_ff);
   assign rsp_data.closest_second   = INDEX_WIDTH'(best_j_ff);
   assign rsp_data.closest_distance = best_d_ff;
   assign rsp_data.pair_found       = found_ff;

   assign n_use = (item_count_ff > COUNT_WIDTH'(TABLE_DIM)) ? COUNT_WIDTH'(TABLE_DIM)
                                                           : item_count_ff;

   assign a_idx  = req_data.first_index[IW-1:0];
   assign b_idx  = req_data.second_index[IW-1:0];
   assign lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
   assign hi_idx = (a_idx < b_idx) ? b_idx : a_idx;

   // Only the upper triangle is ever read, so one slot per pair is enough.
   assign wr_en   = accept && (req_data.operation == OP_WRITE)
                 && (COUNT_WIDTH'(req_data.first_index) < n_use)
                 && (COUNT_WIDTH'(req_data.second_index) < n_use);
   assign wr_addr = {lo_idx, hi_idx};
   assign rd_addr = {i_ff, j_ff};

   assign last_col = (COUNT_WIDTH'(j_ff) == n_use - COUNT_WIDTH'(1));
   assign last_row = (COUNT_WIDTH'(i_ff) == n_use - COUNT_WIDTH'(2));
   assign take     = p_valid_ff && (!found_ff || (rd_data < best_d_ff));

   always_comb begin
      state_in      = state_ff;
      item_count_in = item_count_ff;
      active_in     = active_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      found_in      = found_ff;
      best_i_in     = best_i_ff;
      best_j_in     = best_j_ff;
      best_d_in     = best_d_ff;
      p_valid_in    = (state_ff == ST_SCAN) && active_ff[i_ff] && active_ff[j_ff];
      p_i_in        = i_ff;
      p_j_in        = j_ff;

      if (csr_valid && csr_ready) begin
         item_count_in = csr_data;
      end

      // Compare stage: the read issued last cycle returns now.
      if (take) begin
         found_in  = 1'b1;
         best_i_in = p_i_ff;
         best_j_in = p_j_ff;
         best_d_in = rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_RETIRE: begin
                     if (COUNT_WIDTH'(req_data.second_index) < n_use) begin
                        active_in[b_idx] = 1'b0;
                     end
                  end
                  OP_REACTIVATE: begin
                     active_in = '1;
                  end
                  OP_FIND: begin
                     found_in  = 1'b0;
                     best_i_in = '0;
                     best_j_in = '0;
                     best_d_in = '0;
                     i_in      = '0;
                     j_in      = IW'(1);
                     state_in  = (n_use < COUNT_WIDTH'(2)) ? ST_REPLY : ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (last_col) begin
               if (last_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + IW'(1);
                  j_in = i_ff + IW'(2);
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         item_count_ff <= '0;
         active_ff     <= '1;
         p_valid_ff    <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         active_ff     <= active_in;
         p_valid_ff    <= p_valid_in;
         found_ff      <= found_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      p_i_ff    <= p_i_in;
      p_j_ff    <= p_j_in;
      best_i_ff <= best_i_in;
      best_j_ff <= best_j_in;
      best_d_ff <= best_d_in;
   end

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A compare is pending only while a search is running.
   a_pipe_in_search: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("compare stage active outside a search");

   // The scan stays in the upper triangle.
   a_scan_upper: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff > i_ff))
      else $error("scan address left the upper triangle");

   // A reported pair always has its lower index first.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && found_ff) |-> (best_i_ff < best_j_ff))
      else $error("reported pair out of order");

endmodule

`default_nettype wire

FILE: hdl/capt_ram.sv
`default_nettype none

module capt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
